// File: rtl/pru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

    localparam int LINE_PIXELS = 2048;
    localparam int MAX_SCALE   = 16;
    localparam int ADDR_W      = $clog2(LINE_PIXELS);
    localparam int SCALE_W     = 5;
    localparam int WIDTH_W     = 12;
    localparam int REP_W       = $clog2(MAX_SCALE);
    localparam int PIXEL_W     = 24;
    localparam int CFG_W       = 12;

    typedef enum logic [2:0] {
        KIND_ACCEPT = 3'd0,
        KIND_BUSY   = 3'd1,
        KIND_PIXEL  = 3'd2,
        KIND_PAD    = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    typedef enum logic [0:0] {
        ACT_PUSH = 1'b0,
        ACT_PULL = 1'b1
    } action_t;

    typedef enum logic [0:0] {
        REG_SCALE     = 1'b0,
        REG_ROW_WIDTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic               action;
        logic [PIXEL_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIXEL_W-1:0] pixel_out;
        logic               row_end;
        logic               burst_end;
    } out_item_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        kind_t kind;
        logic  row_end;
        logic  burst_end;
    } result_meta_t;

endpackage

`default_nettype wire

// File: rtl/pru_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pru_line_mem (
    input  wire logic                     clk,
    input  wire pru_pkg::mem_req_t        req,
    output logic [pru_pkg::PIXEL_W-1:0]   rdata
);
    import pru_pkg::*;

    logic [PIXEL_W-1:0] store [LINE_PIXELS];
    logic [PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= store[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/pru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pru_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_en,
    input  wire pru_pkg::cfg_index_t           cfg_index,
    input  wire logic [pru_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          take,
    input  wire pru_pkg::in_item_t             item,
    output pru_pkg::mem_req_t                  req,
    output pru_pkg::result_meta_t              meta
);
    import pru_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;

    logic [ADDR_W-1:0]  fill_reg,  fill_next;
    logic               emit_reg,  emit_next;
    logic [REP_W-1:0]   row_rep_reg, row_rep_next;
    logic [ADDR_W-1:0]  rd_idx_reg,  rd_idx_next;
    logic [REP_W-1:0]   pix_rep_reg, pix_rep_next;
    logic [1:0]         pad_cnt_reg, pad_cnt_next;
    logic               in_pad_reg,  in_pad_next;

    logic [SCALE_W-1:0] s_eff;
    logic [WIDTH_W-1:0] w_eff;
    logic [1:0]         pad;
    logic [3:0]         pad_prod;
    logic               rend;
    logic               bend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(1);
            width_reg <= WIDTH_W'(1);
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_SCALE:     scale_reg <= cfg_data[SCALE_W-1:0];
                REG_ROW_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp the registers into their working ranges
    always_comb
    begin
        if (scale_reg == '0)
            s_eff = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(MAX_SCALE))
            s_eff = SCALE_W'(MAX_SCALE);
        else
            s_eff = scale_reg;

        if (width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(LINE_PIXELS))
            w_eff = WIDTH_W'(LINE_PIXELS);
        else
            w_eff = width_reg;

        // pad bytes = (width * scale) mod 4, since 3 = -1 mod 4
        pad_prod = w_eff[1:0] * s_eff[1:0];
        pad      = pad_prod[1:0];
    end

    always_comb
    begin
        fill_next    = fill_reg;
        emit_next    = emit_reg;
        row_rep_next = row_rep_reg;
        rd_idx_next  = rd_idx_reg;
        pix_rep_next = pix_rep_reg;
        pad_cnt_next = pad_cnt_reg;
        in_pad_next  = in_pad_reg;
        rend         = 1'b0;
        bend         = 1'b0;

        req.wr_en = 1'b0;
        req.rd_en = 1'b0;
        req.addr  = rd_idx_reg;
        req.wdata = item.pixel_in;

        meta.kind = KIND_NONE;

        if (item.action == ACT_PUSH)
        begin
            if (emit_reg)
            begin
                meta.kind = KIND_BUSY;
            end
            else
            begin
                meta.kind = KIND_ACCEPT;
                req.wr_en = take;
                req.addr  = fill_reg;
                if ({1'b0, fill_reg} + WIDTH_W'(1) >= w_eff)
                begin
                    fill_next    = '0;
                    emit_next    = 1'b1;
                    row_rep_next = '0;
                    rd_idx_next  = '0;
                    pix_rep_next = '0;
                    pad_cnt_next = '0;
                    in_pad_next  = 1'b0;
                end
                else
                begin
                    fill_next = fill_reg + ADDR_W'(1);
                end
            end
        end
        else if (emit_reg)
        begin
            if (!in_pad_reg)
            begin
                meta.kind = KIND_PIXEL;
                req.rd_en = take;
                if ({1'b0, pix_rep_reg} + SCALE_W'(1) >= s_eff)
                begin
                    pix_rep_next = '0;
                    if ({1'b0, rd_idx_reg} + WIDTH_W'(1) >= w_eff)
                    begin
                        rd_idx_next = '0;
                        if (pad == 2'd0)
                        begin
                            rend = 1'b1;
                        end
                        else
                        begin
                            in_pad_next  = 1'b1;
                            pad_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    pix_rep_next = pix_rep_reg + REP_W'(1);
                end
            end
            else
            begin
                meta.kind = KIND_PAD;
                if ({1'b0, pad_cnt_reg} + 3'd1 >= {1'b0, pad})
                begin
                    rend         = 1'b1;
                    in_pad_next  = 1'b0;
                    pad_cnt_next = '0;
                end
                else
                begin
                    pad_cnt_next = pad_cnt_reg + 2'd1;
                end
            end

            if (rend)
            begin
                if ({1'b0, row_rep_reg} + SCALE_W'(1) >= s_eff)
                begin
                    bend         = 1'b1;
                    emit_next    = 1'b0;
                    row_rep_next = '0;
                    rd_idx_next  = '0;
                    pix_rep_next = '0;
                    pad_cnt_next = '0;
                    in_pad_next  = 1'b0;
                end
                else
                begin
                    row_rep_next = row_rep_reg + REP_W'(1);
                end
            end
        end

        meta.row_end   = rend;
        meta.burst_end = bend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            emit_reg    <= 1'b0;
            row_rep_reg <= '0;
            rd_idx_reg  <= '0;
            pix_rep_reg <= '0;
            pad_cnt_reg <= '0;
            in_pad_reg  <= 1'b0;
        end
        else if (take)
        begin
            fill_reg    <= fill_next;
            emit_reg    <= emit_next;
            row_rep_reg <= row_rep_next;
            rd_idx_reg  <= rd_idx_next;
            pix_rep_reg <= pix_rep_next;
            pad_cnt_reg <= pad_cnt_next;
            in_pad_reg  <= in_pad_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pixel_row_upscaler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbour integer upscaler for rows of 24-bit pixels.
// Input channel (in_valid/in_ready/in_data): each transaction is a push of
// one pixel into the 2048-entry line buffer or a pull of one output item.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in order: push accepted or refused, a pixel, a pad
// byte, or nothing pending.
// Configuration: cfg_en writes cfg_data into scale (index 0) or row_width
// (index 1) at the clock edge; write only while the block is idle.
// Results are registered: a transaction accepted in one cycle has its result
// presented in the next. Throughput is one transaction per clock unless stalled;
// the single-port line buffer serves one write (push) or one read (pull) per
// cycle, and its registered read data feeds the output stage directly.
// When the receiver stalls, the output register holds its result and
// in_ready drops until it is taken; a new transaction is accepted in the
// same cycle as the pending result leaves.
// Reset clears all counters and returns the block to filling, with scale and
// row_width at 1. Line buffer contents are not cleared and need no sweep.
module pixel_row_upscaler_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_en,
    input  wire pru_pkg::cfg_index_t           cfg_index,
    input  wire logic [pru_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire pru_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output pru_pkg::out_item_t                 out_data
);
    import pru_pkg::*;

    logic               take;
    mem_req_t           req;
    result_meta_t       meta;
    logic [PIXEL_W-1:0] rdata;

    logic               out_valid_reg;
    result_meta_t       meta_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    pru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (in_data),
        .req       (req),
        .meta      (meta)
    );

    pru_line_mem u_mem (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Hold the result while stalled; read data only changes on a pull
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            meta_reg <= meta;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.kind       = meta_reg.kind;
    assign out_data.pixel_out  = (meta_reg.kind == KIND_PIXEL) ? rdata : '0;
    assign out_data.row_end    = meta_reg.row_end;
    assign out_data.burst_end  = meta_reg.burst_end;

endmodule

`default_nettype wire

// File: verif/pru_upscale_checker.sv
`timescale 1ns / 1ps

module pru_upscale_checker
    import pru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_en,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_data,
    output int               errors,
    output int               pending,
    output int               results,
    output logic             bursting
);

    logic [PIXEL_W-1:0] line_pix [LINE_PIXELS];
    logic [WIDTH_W-1:0] fill_pos;
    logic [REP_W-1:0]   row_rep;
    logic [ADDR_W-1:0]  rd_pos;
    logic [REP_W-1:0]   pix_rep;
    logic [1:0]         pad_pos;
    logic               in_pad;
    logic [SCALE_W-1:0] scale_q;
    logic [WIDTH_W-1:0] width_q;
    out_item_t          upscaled_q [$];
    out_item_t          want;

    function automatic int eff_scale();
        int s;
        s = int'(scale_q);
        if (s == 0) s = 1;
        if (s > MAX_SCALE) s = MAX_SCALE;
        return s;
    endfunction

    function automatic int eff_width();
        int w;
        w = int'(width_q);
        if (w == 0) w = 1;
        if (w > LINE_PIXELS) w = LINE_PIXELS;
        return w;
    endfunction

    function automatic void clear_counts();
        row_rep = '0;
        rd_pos  = '0;
        pix_rep = '0;
        pad_pos = '0;
        in_pad  = 1'b0;
    endfunction

    // Advance the predicted upscaler by one transaction and return its result.
    function automatic out_item_t upscale_step(in_item_t xact);
        out_item_t res;
        int        s;
        int        w;
        int        pad;
        s   = eff_scale();
        w   = eff_width();
        res = '0;
        if (xact.action == ACT_PUSH)
        begin
            if (bursting)
            begin
                res.kind = KIND_BUSY;
            end
            else
            begin
                res.kind = KIND_ACCEPT;
                if (fill_pos < LINE_PIXELS) line_pix[fill_pos] = xact.pixel_in;
                if (int'(fill_pos) + 1 >= w)
                begin
                    fill_pos = '0;
                    bursting = 1'b1;
                    clear_counts();
                end
                else
                begin
                    fill_pos = fill_pos + 1'b1;
                end
            end
        end
        else if (!bursting)
        begin
            res.kind = KIND_NONE;
        end
        else
        begin
            // pad bytes bring each output row to a whole number of words
            pad = (4 - (w * s * 3) % 4) % 4;
            if (!in_pad)
            begin
                res.kind      = KIND_PIXEL;
                res.pixel_out = line_pix[rd_pos];
                if (int'(pix_rep) + 1 >= s)
                begin
                    pix_rep = '0;
                    if (int'(rd_pos) + 1 >= w)
                    begin
                        rd_pos = '0;
                        if (pad == 0)
                        begin
                            res.row_end = 1'b1;
                        end
                        else
                        begin
                            in_pad  = 1'b1;
                            pad_pos = '0;
                        end
                    end
                    else
                    begin
                        rd_pos = rd_pos + 1'b1;
                    end
                end
                else
                begin
                    pix_rep = pix_rep + 1'b1;
                end
            end
            else
            begin
                res.kind = KIND_PAD;
                // a pad length that shrank under us still ends the row here
                if (int'(pad_pos) + 1 >= pad)
                begin
                    res.row_end = 1'b1;
                    in_pad      = 1'b0;
                    pad_pos     = '0;
                end
                else
                begin
                    pad_pos = pad_pos + 1'b1;
                end
            end
            if (res.row_end)
            begin
                if (int'(row_rep) + 1 >= s)
                begin
                    res.burst_end = 1'b1;
                    bursting      = 1'b0;
                    clear_counts();
                end
                else
                begin
                    row_rep = row_rep + 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(string field, logic [PIXEL_W-1:0] exp_v,
                                 logic [PIXEL_W-1:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos = '0;
            bursting = 1'b0;
            clear_counts();
            scale_q  = 5'd1;
            width_q  = 12'd1;
            upscaled_q.delete();
            pending  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results++;
                if (upscaled_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no transaction waiting, expected none, got kind %0d",
                             $time, out_data.kind);
                end
                else
                begin
                    want = upscaled_q.pop_front();
                    if (out_data.kind !== want.kind)
                        note_mismatch("kind", want.kind, out_data.kind);
                    if (out_data.pixel_out !== want.pixel_out)
                        note_mismatch("pixel_out", want.pixel_out, out_data.pixel_out);
                    if (out_data.row_end !== want.row_end)
                        note_mismatch("row_end", want.row_end, out_data.row_end);
                    if (out_data.burst_end !== want.burst_end)
                        note_mismatch("burst_end", want.burst_end, out_data.burst_end);
                end
            end
            if (in_valid && in_ready)
                upscaled_q.push_back(upscale_step(in_data));
            if (cfg_en)
            begin
                if (cfg_index == REG_SCALE)
                    scale_q = cfg_data[SCALE_W-1:0];
                else
                    width_q = cfg_data[WIDTH_W-1:0];
            end
            pending = upscaled_q.size();
        end
    end

endmodule

// File: verif/tb_pixel_row_upscaler_unit.sv
`timescale 1ns / 1ps

module tb_pixel_row_upscaler_unit;
    import pru_pkg::*;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_en    = 1'b0;
    cfg_index_t       cfg_index = REG_SCALE;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    out_item_t        out_data;

    int   chk_errors;
    int   chk_pending;
    int   chk_results;
    logic chk_bursting;

    int gap_pct    = 0;
    int stall_pct  = 0;
    int cur_scale  = 1;
    int cur_width  = 1;
    int filled     = 0;
    int xacts      = 0;
    int reg_writes = 0;
    int bursts     = 0;

    pixel_row_upscaler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pru_upscale_checker upscale_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (chk_errors),
        .pending   (chk_pending),
        .results   (chk_results),
        .bursting  (chk_bursting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one transaction and hold it until taken; returns on a falling edge.
    task automatic send(action_t act, logic [PIXEL_W-1:0] pix);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid         = 1'b1;
        in_data.action   = act;
        in_data.pixel_in = pix;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        xacts++;
    endtask

    task automatic push_pixels(int n);
        repeat (n) send(ACT_PUSH, 24'($urandom()));
    endtask

    // Refused pushes are slipped in only ahead of a pull, so never after the burst ends.
    task automatic pull_items(int n, bit with_busy);
        for (int i = 0; i < n; i++)
        begin
            if (with_busy && $urandom_range(0, 15) == 0)
                send(ACT_PUSH, 24'($urandom()));
            send(ACT_PULL, 24'($urandom()));
        end
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        cfg_en    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_en = 1'b0;
        reg_writes++;
        if (idx == REG_SCALE)
        begin
            cur_scale = int'(val[SCALE_W-1:0]);
            if (cur_scale == 0) cur_scale = 1;
            if (cur_scale > MAX_SCALE) cur_scale = MAX_SCALE;
        end
        else
        begin
            cur_width = int'(val);
            if (cur_width == 0) cur_width = 1;
            if (cur_width > LINE_PIXELS) cur_width = LINE_PIXELS;
        end
    endtask

    // Keep scale and width together small enough that a burst stays short.
    task automatic pick_geometry();
        logic [SCALE_W-1:0] s;
        logic [CFG_W-1:0]   w;
        settle();
        if ($urandom_range(0, 4) != 0)
            s = 5'($urandom_range(1, 4));
        else
            s = 5'($urandom_range(0, 31));
        write_reg(REG_SCALE, {7'($urandom_range(0, 127)), s});
        if (cur_scale > 8)
            w = 12'($urandom_range(0, 2));
        else if (cur_scale > 4)
            w = 12'($urandom_range(0, 6));
        else if ($urandom_range(0, 4) != 0)
            w = 12'($urandom_range(1, 12));
        else
            w = 12'($urandom_range(0, 48));
        write_reg(REG_ROW_WIDTH, w);
    endtask

    function automatic int pushes_to_fill();
        return (filled + 1 >= cur_width) ? 1 : cur_width - filled;
    endfunction

    function automatic int burst_items();
        int pad;
        pad = (4 - (cur_width * cur_scale * 3) % 4) % 4;
        return cur_scale * (cur_width * cur_scale + pad);
    endfunction

    // Pull until the burst is over; surplus pulls just report nothing pending.
    task automatic drain_burst();
        settle();
        while (chk_bursting)
        begin
            pull_items($urandom_range(1, 8), 1'b0);
            settle();
        end
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct   = 49;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct   = 0;
                stall_pct = 49;
            end
            default:
            begin
                gap_pct   = 10;
                stall_pct = 10;
            end
        endcase
    endtask

    initial
    begin
        int k;
        int span;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: one pixel, one pad byte per row
        send(ACT_PULL, 24'($urandom()));
        send(ACT_PUSH, 24'hFFFFFF);
        send(ACT_PUSH, 24'h000000);
        pull_items(3, 1'b0);

        // shrink the pad length to nothing while a pad byte is due
        settle();
        write_reg(REG_SCALE, 12'd1);
        write_reg(REG_ROW_WIDTH, 12'd3);
        send(ACT_PUSH, 24'h000000);
        send(ACT_PUSH, 24'hFFFFFF);
        send(ACT_PUSH, 24'($urandom()));
        pull_items(4, 1'b0);
        settle();
        write_reg(REG_SCALE, 12'd4);
        drain_burst();

        // saturating register values: scale beyond the maximum, width zero
        write_reg(REG_SCALE, 12'hFFF);
        write_reg(REG_ROW_WIDTH, 12'h000);
        push_pixels(pushes_to_fill());
        pull_items(burst_items(), 1'b1);

        // widest row that later geometry picks; rows never read past it from here on
        settle();
        write_reg(REG_SCALE, 12'h000);
        write_reg(REG_ROW_WIDTH, 12'd48);
        set_phase(3);
        push_pixels(pushes_to_fill());
        pull_items(burst_items(), 1'b1);

        while (xacts < 1150)
        begin
            set_phase(bursts / 4);
            if (bursts % 5 == 0 || $urandom_range(0, 3) == 0)
                pick_geometry();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send(ACT_PULL, 24'($urandom()));
            span = pushes_to_fill();
            if (span > 1 && $urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(1, span - 1);
                push_pixels(k);
                filled += k;
                pick_geometry();
                span = pushes_to_fill();
            end
            push_pixels(span);
            filled = 0;
            span   = burst_items();
            if ($urandom_range(0, 5) == 0)
            begin
                pull_items($urandom_range(0, span - 1), 1'b1);
                pick_geometry();
                drain_burst();
            end
            else
            begin
                pull_items(span, 1'b1);
            end
            bursts++;
        end

        in_valid = 1'b0;
        k = 0;
        while (chk_pending != 0 && k < 10000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (4) @(negedge clk);
        if (chk_pending != 0)
            $display("%0t: %0d expected results never arrived, got none", $time, chk_pending);
        $display("Ran %0d transactions with %0d random bursts and %0d register writes;",
                 xacts, bursts, reg_writes);
        $display("%0d results checked over widths 1 to 48, scales 1 to 16 with clamping,",
                 chk_results);
        $display("mid-burst register changes and all idle mixes.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_pixel_row_upscaler_unit: clean");
        else
            $display("tb_pixel_row_upscaler_unit: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_pixel_row_upscaler_unit: errors");
        $finish;
    end

endmodule

// File: pixel_row_upscaler_unit.f
rtl/pru_pkg.sv
rtl/pru_line_mem.sv
rtl/pru_ctrl.sv
rtl/pixel_row_upscaler_unit.sv
verif/pru_upscale_checker.sv
verif/tb_pixel_row_upscaler_unit.sv
